[sv/ip_range_country_lookup_macros.svh]
// Assertion helpers used by the range lookup back end.
`ifndef IP_RANGE_COUNTRY_LOOKUP_MACROS_SVH
`define IP_RANGE_COUNTRY_LOOKUP_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define IPRCL_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("range lookup check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define IPRCL_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("range lookup check failed");

`endif

[sv/iprcl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package iprcl_pkg;

  localparam int CNT_W  = 11;
  localparam int IDX_W  = 10;
  localparam int CODE_W = 16;
  localparam int HALF_W = 64;
  localparam int V4_W   = 32;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input field codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;
  localparam logic FAM_V4     = 1'b0;
  localparam logic FAM_V6     = 1'b1;

  // Configuration register indexes
  localparam logic REG_V4_COUNT = 1'b0;
  localparam logic REG_V6_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE4,
    OP_WRITE6,
    OP_LOOK4,
    OP_LOOK6
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   index;
    logic [HALF_W-1:0]  key_hi;
    logic [HALF_W-1:0]  key_lo;
    logic [HALF_W-1:0]  end_hi;
    logic [HALF_W-1:0]  end_lo;
    logic [CODE_W-1:0]  code;
  } item_t;

  typedef struct packed {
    logic [V4_W-1:0]   rng_start;
    logic [V4_W-1:0]   rng_end;
    logic [CODE_W-1:0] code;
  } v4_entry_t;

  typedef struct packed {
    logic [2*HALF_W-1:0] rng_start;
    logic [2*HALF_W-1:0] rng_end;
    logic [CODE_W-1:0]   code;
  } v6_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[sv/iprcl_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module iprcl_front #(
  parameter int V4_DEPTH = 1024,
  parameter int V6_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          req_type,
  input  wire logic                          family,
  input  wire logic [iprcl_pkg::IDX_W-1:0]   entry_index,
  input  wire logic [iprcl_pkg::HALF_W-1:0]  key_hi,
  input  wire logic [iprcl_pkg::HALF_W-1:0]  key_lo,
  input  wire logic [iprcl_pkg::HALF_W-1:0]  end_hi,
  input  wire logic [iprcl_pkg::HALF_W-1:0]  end_lo,
  input  wire logic [iprcl_pkg::CODE_W-1:0]  entry_code,
  output logic                               q_valid,
  output iprcl_pkg::item_t                   q_item,
  input  wire logic                          q_pop
);

  iprcl_pkg::item_t                    items [iprcl_pkg::QDEPTH];
  logic [iprcl_pkg::QPTR_W-1:0]        wr_ptr;
  logic [iprcl_pkg::QPTR_W-1:0]        rd_ptr;
  logic [iprcl_pkg::QCNT_W-1:0]        count;
  iprcl_pkg::item_t                    cls_item;
  logic                                idx_ok;
  logic                                keep;
  logic                                push;

  // Classify the incoming word; IPv4 keeps only the low 32 bits
  always_comb begin
    if (family == iprcl_pkg::FAM_V4) begin
      idx_ok = (32'(entry_index) < 32'(V4_DEPTH));
    end else begin
      idx_ok = (32'(entry_index) < 32'(V6_DEPTH));
    end
    keep = (req_type == iprcl_pkg::REQ_LOOKUP) || idx_ok;

    cls_item.index = entry_index;
    cls_item.code  = entry_code;
    if (family == iprcl_pkg::FAM_V4) begin
      cls_item.op     = (req_type == iprcl_pkg::REQ_LOOKUP) ? iprcl_pkg::OP_LOOK4
                                                             : iprcl_pkg::OP_WRITE4;
      cls_item.key_hi = '0;
      cls_item.key_lo = {{(iprcl_pkg::HALF_W - iprcl_pkg::V4_W){1'b0}},
                         key_lo[iprcl_pkg::V4_W-1:0]};
      cls_item.end_hi = '0;
      cls_item.end_lo = {{(iprcl_pkg::HALF_W - iprcl_pkg::V4_W){1'b0}},
                         end_lo[iprcl_pkg::V4_W-1:0]};
    end else begin
      cls_item.op     = (req_type == iprcl_pkg::REQ_LOOKUP) ? iprcl_pkg::OP_LOOK6
                                                             : iprcl_pkg::OP_WRITE6;
      cls_item.key_hi = key_hi;
      cls_item.key_lo = key_lo;
      cls_item.end_hi = end_hi;
      cls_item.end_lo = end_lo;
    end
  end

  // Accept while the queue has room; drop writes aimed past the table
  assign in_ready = (count != iprcl_pkg::QCNT_W'(iprcl_pkg::QDEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != '0);
  assign q_item   = items[rd_ptr];

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == iprcl_pkg::QPTR_W'(iprcl_pkg::QDEPTH - 1)) ? '0
                                                                         : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == iprcl_pkg::QPTR_W'(iprcl_pkg::QDEPTH - 1)) ? '0
                                                                         : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (q_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      items[wr_ptr] <= cls_item;
    end
  end

endmodule

`default_nettype wire

[sv/iprcl_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ip_range_country_lookup_macros.svh"

module iprcl_back #(
  parameter int V4_DEPTH = 1024,
  parameter int V6_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [iprcl_pkg::CNT_W-1:0]   v4_count,
  input  wire logic [iprcl_pkg::CNT_W-1:0]   v6_count,
  input  wire logic                          q_valid,
  input  wire iprcl_pkg::item_t              q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               found,
  output logic [iprcl_pkg::CODE_W-1:0]       country_code
);

  localparam int A4_W = $clog2(V4_DEPTH);
  localparam int A6_W = $clog2(V6_DEPTH);
  localparam int KEY_W = 2 * iprcl_pkg::HALF_W;

  iprcl_pkg::v4_entry_t               mem4 [V4_DEPTH];
  iprcl_pkg::v6_entry_t               mem6 [V6_DEPTH];
  iprcl_pkg::v4_entry_t               rd4;
  iprcl_pkg::v6_entry_t               rd6;

  iprcl_pkg::state_t                  state, state_next;
  logic [iprcl_pkg::CNT_W-1:0]        lo, lo_next;
  logic [iprcl_pkg::CNT_W-1:0]        hi, hi_next;
  logic [iprcl_pkg::CNT_W-1:0]        mid, mid_next;
  logic [iprcl_pkg::CNT_W-1:0]        rd_idx;
  logic                               fam6;
  logic [KEY_W-1:0]                   key;
  logic                               res_found, res_found_next;
  logic [iprcl_pkg::CODE_W-1:0]       res_code, res_code_next;

  logic [iprcl_pkg::CNT_W-1:0]        n4, n6, n_sel;
  logic [iprcl_pkg::CNT_W-1:0]        lo_step, hi_step;
  logic [KEY_W-1:0]                   cur_start, cur_end;
  logic [iprcl_pkg::CODE_W-1:0]       cur_code;
  logic                               start_eq, start_lt, in_range;
  logic                               is_lookup, out_free;

  // Clamp the entry counts to the table depth
  assign n4 = (32'(v4_count) > 32'(V4_DEPTH)) ? iprcl_pkg::CNT_W'(V4_DEPTH) : v4_count;
  assign n6 = (32'(v6_count) > 32'(V6_DEPTH)) ? iprcl_pkg::CNT_W'(V6_DEPTH) : v6_count;
  assign n_sel = (q_item.op == iprcl_pkg::OP_LOOK6) ? n6 : n4;

  assign is_lookup = (q_item.op == iprcl_pkg::OP_LOOK4) ||
                     (q_item.op == iprcl_pkg::OP_LOOK6);
  assign out_free  = !out_valid || out_ready;

  // Widen the entry just read to a common compare width
  always_comb begin
    if (fam6) begin
      cur_start = rd6.rng_start;
      cur_end   = rd6.rng_end;
      cur_code  = rd6.code;
    end else begin
      cur_start = {{(KEY_W - iprcl_pkg::V4_W){1'b0}}, rd4.rng_start};
      cur_end   = {{(KEY_W - iprcl_pkg::V4_W){1'b0}}, rd4.rng_end};
      cur_code  = rd4.code;
    end
    start_eq = (cur_start == key);
    start_lt = (cur_start < key);
    in_range = (key >= cur_start) && (key <= cur_end);
    lo_step  = start_lt ? mid + 1'b1 : lo;
    hi_step  = start_lt ? hi : mid;
  end

  // Search sequencer: one table read per step
  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    rd_idx         = mid;
    q_pop          = 1'b0;
    res_found_next = res_found;
    res_code_next  = res_code;
    case (state)
      iprcl_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (is_lookup) begin
            lo_next = '0;
            hi_next = n_sel;
            if (n_sel != '0) begin
              mid_next   = n_sel >> 1;
              rd_idx     = n_sel >> 1;
              state_next = iprcl_pkg::ST_LOOK;
            end else begin
              res_found_next = 1'b0;
              res_code_next  = '0;
              state_next     = iprcl_pkg::ST_DONE;
            end
          end
        end
      end
      iprcl_pkg::ST_LOOK: begin
        if (start_eq) begin
          res_found_next = 1'b1;
          res_code_next  = cur_code;
          state_next     = iprcl_pkg::ST_DONE;
        end else begin
          lo_next = lo_step;
          hi_next = hi_step;
          if (lo_step < hi_step) begin
            mid_next = lo_step + ((hi_step - lo_step) >> 1);
            rd_idx   = lo_step + ((hi_step - lo_step) >> 1);
          end else if (lo_step != '0) begin
            rd_idx     = lo_step - 1'b1;
            state_next = iprcl_pkg::ST_CHECK;
          end else begin
            res_found_next = 1'b0;
            res_code_next  = '0;
            state_next     = iprcl_pkg::ST_DONE;
          end
        end
      end
      iprcl_pkg::ST_CHECK: begin
        res_found_next = in_range;
        res_code_next  = in_range ? cur_code : '0;
        state_next     = iprcl_pkg::ST_DONE;
      end
      iprcl_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = iprcl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = iprcl_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer state and search bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iprcl_pkg::ST_IDLE;
      lo    <= '0;
      hi    <= '0;
      mid   <= '0;
    end else begin
      state <= state_next;
      lo    <= lo_next;
      hi    <= hi_next;
      mid   <= mid_next;
    end
  end

  // Hold the lookup key and the pending answer
  always_ff @(posedge clk) begin
    if (q_pop && is_lookup) begin
      fam6 <= (q_item.op == iprcl_pkg::OP_LOOK6);
      key  <= {q_item.key_hi, q_item.key_lo};
    end
    res_found <= res_found_next;
    res_code  <= res_code_next;
  end

  // IPv4 table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == iprcl_pkg::OP_WRITE4) begin
      mem4[A4_W'(q_item.index)] <= '{rng_start: q_item.key_lo[iprcl_pkg::V4_W-1:0],
                                     rng_end:   q_item.end_lo[iprcl_pkg::V4_W-1:0],
                                     code:      q_item.code};
    end
    rd4 <= mem4[A4_W'(rd_idx)];
  end

  // IPv6 table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == iprcl_pkg::OP_WRITE6) begin
      mem6[A6_W'(q_item.index)] <= '{rng_start: {q_item.key_hi, q_item.key_lo},
                                     rng_end:   {q_item.end_hi, q_item.end_lo},
                                     code:      q_item.code};
    end
    rd6 <= mem6[A6_W'(rd_idx)];
  end

  // Output register: load the answer once the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == iprcl_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == iprcl_pkg::ST_DONE && out_free) begin
      found        <= res_found;
      country_code <= res_code;
    end
  end

  `IPRCL_ASSERT_IMP(a_bounds_ordered, clk, rst, state != iprcl_pkg::ST_IDLE, lo <= hi)
  `IPRCL_ASSERT_IMP(a_look_open, clk, rst, state == iprcl_pkg::ST_LOOK, lo < hi)
  `IPRCL_ASSERT_IMP(a_pop_idle, clk, rst, q_pop, state == iprcl_pkg::ST_IDLE && q_valid)
  `IPRCL_ASSERT_IMP(a_miss_zero, clk, rst, out_valid && !found, country_code == '0)
  `IPRCL_ASSERT_NEXT(a_done_loads, clk, rst, state == iprcl_pkg::ST_DONE && out_free,
                     out_valid)

endmodule

`default_nettype wire

[sv/ip_range_country_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none

// IPv4/IPv6 range-to-country lookup. Words enter a two-deep queue and are
// executed in order by a search engine; a table write gives no result, and a
// write to a slot at or past the table depth is dropped. A lookup binary-
// searches the first entry_count entries (clamped to the depth) with one
// read of the table memory per step, and its answer may wait for the output
// register. The tables are sorted by the user; entries must be written before
// a lookup reaches them, and there is no clearing pass after reset. The user
// must write counts on the config port only while the block is idle; the
// block itself does not enforce this.
module ip_range_country_lookup #(
  parameter int V4_DEPTH = 1024,
  parameter int V6_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic                          cfg_index,
  input  wire logic [iprcl_pkg::CNT_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          req_type,
  input  wire logic                          family,
  input  wire logic [iprcl_pkg::IDX_W-1:0]   entry_index,
  input  wire logic [iprcl_pkg::HALF_W-1:0]  key_hi,
  input  wire logic [iprcl_pkg::HALF_W-1:0]  key_lo,
  input  wire logic [iprcl_pkg::HALF_W-1:0]  end_hi,
  input  wire logic [iprcl_pkg::HALF_W-1:0]  end_lo,
  input  wire logic [iprcl_pkg::CODE_W-1:0]  entry_code,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               found,
  output logic [iprcl_pkg::CODE_W-1:0]       country_code
);

  logic [iprcl_pkg::CNT_W-1:0]  v4_entry_count;
  logic [iprcl_pkg::CNT_W-1:0]  v6_entry_count;
  logic                         q_valid;
  logic                         q_pop;
  iprcl_pkg::item_t             q_item;

  // Count registers take a word every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4_entry_count <= '0;
      v6_entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        iprcl_pkg::REG_V4_COUNT: v4_entry_count <= cfg_data;
        iprcl_pkg::REG_V6_COUNT: v6_entry_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  iprcl_front #(
    .V4_DEPTH (V4_DEPTH),
    .V6_DEPTH (V6_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .family      (family),
    .entry_index (entry_index),
    .key_hi      (key_hi),
    .key_lo      (key_lo),
    .end_hi      (end_hi),
    .end_lo      (end_lo),
    .entry_code  (entry_code),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  iprcl_back #(
    .V4_DEPTH (V4_DEPTH),
    .V6_DEPTH (V6_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .v4_count     (v4_entry_count),
    .v6_count     (v6_entry_count),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .country_code (country_code)
  );

endmodule

`default_nettype wire
